// ===== hw/rtl/ema_crossover_signal_core_assert.svh =====
// Assertion macros shared by the crossover signal core modules.
// Both sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef EMA_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define EMA_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

`define ECS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ECS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecs_pkg.sv =====
// ----------------------------------------------------------------------------
// ecs_pkg
// Types and constants shared by the crossover signal core.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int LONG_TAPS  = 11;
  localparam int SHORT_TAPS = 6;

  localparam int PRICE_W   = 32;
  localparam int TIME_W    = 32;
  localparam int Q_W       = 16;
  localparam int MULT_W    = Q_W + 1;
  localparam int TERM_W    = PRICE_W + Q_W;
  localparam int SUM_W     = TERM_W + $clog2(LONG_TAPS);
  localparam int LO_W      = 32;
  localparam int HI_W      = SUM_W - LO_W;
  localparam int PROD_LO_W = MULT_W + LO_W;
  localparam int PROD_HI_W = MULT_W + HI_W;
  localparam int PROD_W    = MULT_W + SUM_W;
  localparam int CNT_W     = $clog2(LONG_TAPS + 1);
  localparam int IDX_W     = $clog2(LONG_TAPS);

  localparam logic [MULT_W-1:0] Q_ONE = MULT_W'(1) << Q_W;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = CFG_IDX_W'(1);

  localparam logic [Q_W-1:0] ALPHA_RESET  = Q_W'(26214);
  localparam logic [Q_W-1:0] MARGIN_RESET = Q_W'(3277);

  typedef struct packed {
    logic [PRICE_W-1:0] open_price;
    logic [TIME_W-1:0]  bar_time;
  } in_t;

  typedef struct packed {
    logic              signal_direction;
    logic [TIME_W-1:0] signal_time;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic cmp_lo;
    logic cmp_hi;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic fire;
  } status_t;

endpackage

// ===== hw/rtl/ecs_datapath.sv =====
// ----------------------------------------------------------------------------
// ecs_datapath
// Price history, weight recursion, shared multiply-accumulate and the
// split-product crossover test, driven by commands from the controller.
// ----------------------------------------------------------------------------
`include "ema_crossover_signal_core_assert.svh"

module ecs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ecs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  ecs_pkg::in_t                    in_data_i,
  input  ecs_pkg::cmd_t                   cmd_i,
  output ecs_pkg::status_t                status_o,
  output ecs_pkg::out_t                   out_data_o
);
  import ecs_pkg::*;

  logic [Q_W-1:0]       alpha_q, margin_q;
  logic [CNT_W-1:0]     bars_q, k_q;
  logic                 holding_q;
  logic [PRICE_W-1:0]   hist_q [LONG_TAPS];
  logic [TIME_W-1:0]    time_q;
  logic [Q_W-1:0]       w_q;
  logic [TERM_W-1:0]    term_q;
  logic [SUM_W-1:0]     long_q, short_q;
  logic [PROD_LO_W-1:0] pl_q;
  logic [PROD_HI_W-1:0] ph_q;
  out_t                 out_q;

  logic [MULT_W-1:0]    decay;
  logic [Q_W+MULT_W-1:0] w_prod;
  logic [Q_W-1:0]       w_next;
  logic [TERM_W-1:0]    term_next;
  logic [CNT_W-1:0]     n_short;
  logic [MULT_W-1:0]    mult;
  logic [SUM_W-1:0]     lhs_sum, rhs_sum;
  logic [PROD_W-1:0]    lhs, rhs;

  always_comb begin
    decay     = Q_ONE - {1'b0, alpha_q};
    w_prod    = w_q * decay;
    w_next    = Q_W'((w_prod + (Q_W+MULT_W)'(32768)) >> Q_W);
    term_next = hist_q[k_q[IDX_W-1:0]] * w_q;
    n_short   = (bars_q < CNT_W'(SHORT_TAPS)) ? bars_q : CNT_W'(SHORT_TAPS);
    if (holding_q) begin
      mult    = Q_ONE + {1'b0, margin_q};
      lhs_sum = long_q;
      rhs_sum = short_q;
    end else begin
      mult    = Q_ONE - {1'b0, margin_q};
      lhs_sum = short_q;
      rhs_sum = long_q;
    end
    lhs = PROD_W'(lhs_sum) << Q_W;
    rhs = (PROD_W'(ph_q) << LO_W) + PROD_W'(pl_q);
  end

  assign status_o.last_tap = ((k_q + CNT_W'(1)) == bars_q);
  assign status_o.fire     = (lhs > rhs);
  assign out_data_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RESET;
      margin_q  <= MARGIN_RESET;
      bars_q    <= '0;
      k_q       <= '0;
      holding_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SMOOTHING: alpha_q  <= cfg_data_i;
          CFG_MARGIN:    margin_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        k_q <= '0;
        if (bars_q < CNT_W'(LONG_TAPS)) begin
          bars_q <= bars_q + CNT_W'(1);
        end
      end
      if (cmd_i.acc) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        holding_q <= ~holding_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hist_q[0] <= in_data_i.open_price;
      for (int i = 1; i < LONG_TAPS; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      time_q  <= in_data_i.bar_time;
      w_q     <= alpha_q;
      long_q  <= '0;
      short_q <= '0;
    end
    if (cmd_i.mul) begin
      term_q <= term_next;
      w_q    <= w_next;
    end
    if (cmd_i.acc) begin
      long_q <= long_q + SUM_W'(term_q);
      if (k_q < n_short) begin
        short_q <= short_q + SUM_W'(term_q);
      end
    end
    if (cmd_i.cmp_lo) begin
      pl_q <= mult * rhs_sum[LO_W-1:0];
    end
    if (cmd_i.cmp_hi) begin
      ph_q <= mult * rhs_sum[SUM_W-1:LO_W];
    end
    if (cmd_i.emit) begin
      out_q.signal_direction <= holding_q;
      out_q.signal_time      <= time_q;
    end
  end

  `ECS_ASSERT(a_tap_in_window, cmd_i.mul |-> (k_q < bars_q), "Tap read beyond the bars held.")
  `ECS_ASSERT(a_bars_bound, bars_q <= CNT_W'(LONG_TAPS), "Bar count above window.")
  `ECS_ASSERT_NEXT(a_emit_toggles, cmd_i.emit, holding_q != $past(holding_q), "No flag toggle.")

endmodule

// ===== hw/rtl/ecs_controller.sv =====
// ----------------------------------------------------------------------------
// ecs_controller
// Sequencer for one bar: load, multiply and accumulate per tap, two partial
// products for the test, then decide and pass a firing signal to the output stage.
// ----------------------------------------------------------------------------
`include "ema_crossover_signal_core_assert.svh"

module ecs_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ecs_pkg::status_t status_i,
  output ecs_pkg::cmd_t    cmd_o
);
  import ecs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_CMP_LO = 3'd3;
  localparam logic [2:0] S_CMP_HI = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last_tap ? S_CMP_LO : S_MUL;
      end
      S_CMP_LO: begin
        cmd_o.cmp_lo = 1'b1;
        state_d      = S_CMP_HI;
      end
      S_CMP_HI: begin
        cmd_o.cmp_hi = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status_i.fire) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ECS_ASSERT(a_emit_slot, cmd_o.emit |-> (!out_valid_q || out_ready_i), "Beat overwritten.")
  `ECS_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_MUL, "No tap walk.")
  `ECS_ASSERT_NEXT(a_loop, state_q == S_ACC && !status_i.last_tap, state_q == S_MUL, "Cut short.")

endmodule

// ===== hw/rtl/ema_crossover_signal_core.sv =====
// ----------------------------------------------------------------------------
// ema_crossover_signal_core: one bar in, at most one buy or sell beat out.
// With n taps (n = bars held, at most 11) the shared multiply-accumulate walks the
// taps, then the test is decided; a new bar is taken only in idle, after any firing
// beat finds the output slot free. Reset clears the bar count and holding flag.
// ----------------------------------------------------------------------------
module ema_crossover_signal_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ecs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ecs_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ecs_pkg::out_t                   out_data_o
);
  import ecs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ecs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ecs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule
